// File: sv/iatc_pkg.sv
package iatc_pkg;

   // result codes carried in the version field
   localparam logic [1:0] VER_INVALID = 2'd0;
   localparam logic [1:0] VER_IPV4    = 2'd1;
   localparam logic [1:0] VER_IPV6    = 2'd2;

   // characters of interest
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;

   localparam logic [11:0] OCTET_MAX     = 12'd255;
   localparam logic [1:0]  OCTET_LAST    = 2'd3;
   localparam logic [2:0]  HEX_DIGIT_MAX = 3'd4;
   localparam logic [3:0]  GROUP_MAX     = 4'd8;
   localparam logic [3:0]  GROUP_TAIL_LIM = 4'd7;
   localparam logic [3:0]  TAIL_GROUPS   = 4'd2;

   typedef struct packed {
      logic just_colon;
      logic dcolon_ok;
      logic colon_ok;
      logic digit_ok;
      logic required;
   } iatc_v6_flags_type;

   localparam iatc_v6_flags_type V6_FLAGS_RESET = '{
      just_colon: 1'b0,
      dcolon_ok:  1'b1,
      colon_ok:   1'b1,
      digit_ok:   1'b1,
      required:   1'b1
   };

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // value * 10 + decimal digit, wide enough for any 8-bit value
   function automatic logic [11:0] dec_acc(input logic [7:0] value, input logic [7:0] c);
      return ({4'b0, value} << 3) + ({4'b0, value} << 1) + {8'b0, c[3:0]};
   endfunction

endpackage

// File: sv/ip_address_text_classifier_core.sv
// Address text classifier. Send the text one byte per beat on req_, ending
// with a zero byte; for that zero byte one beat leaves on rsp_ with the
// version: 0 invalid, 1 dotted IPv4, 2 IPv6 (IPv4 wins when both hold). Any
// other byte gives no beat. A byte is taken every cycle while req_tready is
// high: each byte updates the small counter and flag state of the IPv4 and
// IPv6 checkers, and a zero byte's result is registered in the output stage
// or, while it is full, in the skid. A two-deep output stage keeps input
// flowing while a result waits; req_tready drops only while two results are
// held. All checker state returns to its reset value after each zero byte.
module ip_address_text_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] version, [7:2] zero
);
   import iatc_pkg::*;

   logic       req_beat;
   logic       end_beat;
   logic       ipv4_ok, ipv6_ok;
   logic [1:0] version;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_ver_ff, out_ver_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [1:0] skid_ver_ff, skid_ver_in;

   assign req_tready = !skid_valid_ff;
   assign req_beat   = req_tvalid && req_tready;
   assign end_beat   = req_beat && (req_tdata == CH_NUL);

   iatc_v4_chk u_v4 (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_beat),
      .char_in    (req_tdata),
      .ipv4_ok    (ipv4_ok)
   );

   iatc_v6_chk u_v6 (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_beat),
      .char_in    (req_tdata),
      .ipv6_ok    (ipv6_ok)
   );

   assign version = ipv4_ok ? VER_IPV4 : (ipv6_ok ? VER_IPV6 : VER_INVALID);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ver_in    = out_ver_ff;
      skid_valid_in = skid_valid_ff;
      skid_ver_in   = skid_ver_ff;
      if (skid_valid_ff) begin
         // no new result can arrive while the skid is full
         if (rsp_tready) begin
            out_ver_in    = skid_ver_ff;
            skid_valid_in = 1'b0;
         end
      end else if (end_beat) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_ver_in   = version;
         end else begin
            skid_valid_in = 1'b1;
            skid_ver_in   = version;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ver_ff  <= out_ver_in;
      skid_ver_ff <= skid_ver_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ver_ff};

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result with the output stage empty");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      end_beat |=> rsp_tvalid)
      else $error("end byte did not produce a result");

   a_version_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ver_ff == VER_INVALID || out_ver_ff == VER_IPV4
                      || out_ver_ff == VER_IPV6))
      else $error("result carries an unknown version code");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (!skid_valid_ff && rsp_tvalid
                                         && out_ver_ff == $past(skid_ver_ff)))
      else $error("held result lost when the skid drained");
`endif

endmodule

// File: sv/iatc_v4_chk.sv
module iatc_v4_chk (
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_valid,
   input  logic [7:0] char_in,
   output logic       ipv4_ok
);
   import iatc_pkg::*;

   logic        failed_ff, failed_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  value_ff, value_in;
   logic        seen_ff, seen_in;
   logic [11:0] acc;

   always_comb begin
      failed_in = failed_ff;
      count_in  = count_ff;
      value_in  = value_ff;
      seen_in   = seen_ff;
      acc       = dec_acc(value_ff, char_in);
      if (beat_valid) begin
         if (char_in == CH_NUL) begin
            failed_in = 1'b0;
            count_in  = '0;
            value_in  = '0;
            seen_in   = 1'b0;
         end else if (!failed_ff) begin
            if (is_dec(char_in)) begin
               if (acc > OCTET_MAX) begin
                  failed_in = 1'b1;
               end else begin
                  value_in = acc[7:0];
                  seen_in  = 1'b1;
               end
            end else if (char_in == CH_DOT) begin
               if (!seen_ff || count_ff == OCTET_LAST) begin
                  failed_in = 1'b1;
               end else begin
                  count_in = count_ff + 2'd1;
                  value_in = '0;
                  seen_in  = 1'b0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff <= 1'b0;
         count_ff  <= '0;
         value_ff  <= '0;
         seen_ff   <= 1'b0;
      end else begin
         failed_ff <= failed_in;
         count_ff  <= count_in;
         value_ff  <= value_in;
         seen_ff   <= seen_in;
      end
   end

   assign ipv4_ok = !failed_ff && seen_ff && (count_ff == OCTET_LAST);

endmodule

// File: sv/iatc_v6_chk.sv
module iatc_v6_chk (
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_valid,
   input  logic [7:0] char_in,
   output logic       ipv6_ok
);
   import iatc_pkg::*;

   logic              failed_ff, failed_in;
   logic [2:0]        digits_ff, digits_in;
   logic [3:0]        count_ff, count_in;
   iatc_v6_flags_type flags_ff, flags_in;
   logic              tail_ff, tail_in;
   logic [7:0]        decval_ff, decval_in;
   logic              alldec_ff, alldec_in;
   logic [1:0]        tail_oct_ff, tail_oct_in;
   logic [11:0]       acc;
   logic              dec, hex;
   logic              fin_ok;
   logic [3:0]        fin_count;

   always_comb begin
      failed_in   = failed_ff;
      digits_in   = digits_ff;
      count_in    = count_ff;
      flags_in    = flags_ff;
      tail_in     = tail_ff;
      decval_in   = decval_ff;
      alldec_in   = alldec_ff;
      tail_oct_in = tail_oct_ff;
      acc = dec_acc(decval_ff, char_in);
      dec = is_dec(char_in);
      hex = dec || ((char_in >= CH_LOW_A) && (char_in <= CH_LOW_F))
                || ((char_in >= CH_UP_A) && (char_in <= CH_UP_F));
      if (beat_valid) begin
         if (char_in == CH_NUL) begin
            failed_in   = 1'b0;
            digits_in   = '0;
            count_in    = '0;
            flags_in    = V6_FLAGS_RESET;
            tail_in     = 1'b0;
            decval_in   = '0;
            alldec_in   = 1'b1;
            tail_oct_in = '0;
         end else if (failed_ff) begin
            failed_in = 1'b1;
         end else if (tail_ff) begin
            // dotted ipv4 tail
            if (dec) begin
               if (acc > OCTET_MAX) begin
                  failed_in = 1'b1;
               end else begin
                  decval_in = acc[7:0];
                  digits_in = 3'd1;
               end
            end else if (char_in == CH_DOT) begin
               if (digits_ff == '0 || tail_oct_ff == OCTET_LAST) begin
                  failed_in = 1'b1;
               end else begin
                  tail_oct_in = tail_oct_ff + 2'd1;
                  decval_in   = '0;
                  digits_in   = '0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end else if (hex) begin
            if (!flags_ff.digit_ok || digits_ff == HEX_DIGIT_MAX) begin
               failed_in = 1'b1;
            end else begin
               digits_in           = digits_ff + 3'd1;
               flags_in.colon_ok   = 1'b1;
               flags_in.just_colon = 1'b0;
               if (!dec) begin
                  alldec_in = 1'b0;
               end else if (alldec_ff) begin
                  if (acc > OCTET_MAX) alldec_in = 1'b0;
                  else decval_in = acc[7:0];
               end
            end
         end else if (char_in == CH_COLON) begin
            if (!flags_ff.colon_ok) begin
               failed_in = 1'b1;
            end else if (flags_ff.just_colon) begin
               // second colon of a double colon
               flags_in.digit_ok  = 1'b1;
               flags_in.colon_ok  = 1'b0;
               flags_in.required  = 1'b0;
               flags_in.dcolon_ok = 1'b0;
            end else if (count_ff == GROUP_MAX) begin
               failed_in = 1'b1;
            end else if (digits_ff == '0 && count_ff == '0) begin
               // leading colon, only a double colon may follow
               flags_in.colon_ok   = 1'b1;
               flags_in.just_colon = 1'b1;
               flags_in.required   = 1'b1;
               flags_in.digit_ok   = 1'b0;
            end else begin
               count_in            = count_ff + 4'd1;
               digits_in           = '0;
               decval_in           = '0;
               alldec_in           = 1'b1;
               flags_in.colon_ok   = flags_ff.dcolon_ok;
               flags_in.just_colon = 1'b1;
               flags_in.required   = 1'b1;
            end
         end else if (char_in == CH_DOT) begin
            if (count_ff >= GROUP_TAIL_LIM || digits_ff == '0 || !alldec_ff) begin
               failed_in = 1'b1;
            end else begin
               tail_in     = 1'b1;
               tail_oct_in = 2'd1;
               decval_in   = '0;
               digits_in   = '0;
            end
         end else begin
            failed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff   <= 1'b0;
         digits_ff   <= '0;
         count_ff    <= '0;
         flags_ff    <= V6_FLAGS_RESET;
         tail_ff     <= 1'b0;
         decval_ff   <= '0;
         alldec_ff   <= 1'b1;
         tail_oct_ff <= '0;
      end else begin
         failed_ff   <= failed_in;
         digits_ff   <= digits_in;
         count_ff    <= count_in;
         flags_ff    <= flags_in;
         tail_ff     <= tail_in;
         decval_ff   <= decval_in;
         alldec_ff   <= alldec_in;
         tail_oct_ff <= tail_oct_in;
      end
   end

   // end-of-string verdict from the current state
   always_comb begin
      fin_ok    = !failed_ff;
      fin_count = count_ff;
      if (tail_ff) begin
         if (tail_oct_ff != OCTET_LAST || digits_ff == '0) fin_ok = 1'b0;
         else fin_count = count_ff + TAIL_GROUPS;
      end else if (digits_ff != '0) begin
         if (count_ff == GROUP_MAX) fin_ok = 1'b0;
         else fin_count = count_ff + 4'd1;
      end else if (flags_ff.required) begin
         fin_ok = 1'b0;
      end
      ipv6_ok = fin_ok && (!flags_ff.dcolon_ok || fin_count == GROUP_MAX);
   end

endmodule

// File: tb/ip_address_text_classifier_core_tb.sv
module ip_address_text_classifier_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iatc_pkg::*;

   localparam int RANDOM_BYTES = 530;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int CALM_BYTES   = 120;

   typedef logic [7:0] text_q_t[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_in
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [1:0] version, [7:2] zero

   ip_address_text_classifier_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // bytes still to send and versions still to arrive
   logic [7:0] text_q[$];
   logic [1:0] verdict_q[$];

   int  fail_count;
   int  sent_bytes;
   int  text_count;
   int  calm_mark;
   int  cycles;
   int  n_v4, n_v6, n_bad;
   bit  calm;
   int  req_idle_pct, rsp_idle_pct;

   // classifier shadow state
   logic                v4_bad;
   logic [1:0]          v4_cnt;
   logic [7:0]          v4_val;
   logic                v4_dig;
   logic                v6_bad;
   logic [2:0]          v6_digits;
   logic [3:0]          v6_groups;
   iatc_v6_flags_type   v6_fl;
   logic                v6_tail;
   logic [7:0]          v6_decval;
   logic                v6_alldec;
   logic [1:0]          v6_toct;

   task automatic clear_state();
      v4_bad = 1'b0; v4_cnt = '0; v4_val = '0; v4_dig = 1'b0;
      v6_bad = 1'b0; v6_digits = '0; v6_groups = '0;
      v6_fl = V6_FLAGS_RESET;
      v6_tail = 1'b0; v6_decval = '0; v6_alldec = 1'b1; v6_toct = '0;
   endtask

   function automatic bit v6_accepts();
      int count;
      count = v6_groups;
      if (v6_bad) return 1'b0;
      if (v6_tail) begin
         if (v6_toct != 2'd3 || v6_digits == 0) return 1'b0;
         count += 2;
      end else if (v6_digits > 0) begin
         if (count == 8) return 1'b0;
         count += 1;
      end else if (v6_fl.required) begin
         return 1'b0;
      end
      return !v6_fl.dcolon_ok || count == 8;
   endfunction

   task automatic v6_step(input logic [7:0] c, input bit isdig, input bit ishex);
      int v;
      if (v6_tail) begin
         if (isdig) begin
            v = int'(v6_decval) * 10 + int'(c - CH_ZERO);
            if (v > 255) v6_bad = 1'b1;
            else begin
               v6_decval = v[7:0];
               v6_digits = 3'd1;
            end
         end else if (c == CH_DOT) begin
            if (v6_digits == 0 || v6_toct == 2'd3) v6_bad = 1'b1;
            else begin
               v6_toct++;
               v6_decval = '0;
               v6_digits = '0;
            end
         end else begin
            v6_bad = 1'b1;
         end
         return;
      end
      if (ishex) begin
         if (!v6_fl.digit_ok || v6_digits == 3'd4) begin
            v6_bad = 1'b1;
            return;
         end
         v6_digits++;
         v6_fl.colon_ok = 1'b1;
         v6_fl.just_colon = 1'b0;
         if (!isdig) v6_alldec = 1'b0;
         else if (v6_alldec) begin
            v = int'(v6_decval) * 10 + int'(c - CH_ZERO);
            if (v > 255) v6_alldec = 1'b0;
            else v6_decval = v[7:0];
         end
      end else if (c == CH_COLON) begin
         if (!v6_fl.colon_ok) begin
            v6_bad = 1'b1;
            return;
         end
         if (v6_fl.just_colon) begin
            // second colon of the one double colon
            v6_fl.digit_ok = 1'b1;
            v6_fl.colon_ok = 1'b0;
            v6_fl.required = 1'b0;
            v6_fl.dcolon_ok = 1'b0;
            return;
         end
         if (v6_groups == 4'd8) begin
            v6_bad = 1'b1;
            return;
         end
         if (v6_digits == 0 && v6_groups == 0) begin
            // leading colon, only a second colon may follow
            v6_fl.colon_ok = 1'b1;
            v6_fl.just_colon = 1'b1;
            v6_fl.required = 1'b1;
            v6_fl.digit_ok = 1'b0;
            return;
         end
         v6_groups++;
         v6_digits = '0;
         v6_decval = '0;
         v6_alldec = 1'b1;
         v6_fl.colon_ok = v6_fl.dcolon_ok;
         v6_fl.just_colon = 1'b1;
         v6_fl.required = 1'b1;
      end else if (c == CH_DOT) begin
         if (v6_groups >= 4'd7 || v6_digits == 0 || !v6_alldec) begin
            v6_bad = 1'b1;
            return;
         end
         v6_tail = 1'b1;
         v6_toct = 2'd1;
         v6_decval = '0;
         v6_digits = '0;
      end else begin
         v6_bad = 1'b1;
      end
   endtask

   task automatic classify_byte(input logic [7:0] c);
      int         v;
      bit         isdig;
      bit         ishex;
      logic [1:0] ver;
      isdig = (c >= CH_ZERO) && (c <= CH_NINE);
      ishex = isdig || (c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F);
      if (c == CH_NUL) begin
         if (!v4_bad && v4_dig && v4_cnt == 2'd3) ver = VER_IPV4;
         else if (v6_accepts()) ver = VER_IPV6;
         else ver = VER_INVALID;
         verdict_q.push_back(ver);
         if (ver == VER_IPV4) n_v4++;
         else if (ver == VER_IPV6) n_v6++;
         else n_bad++;
         clear_state();
         return;
      end
      if (!v4_bad) begin
         if (isdig) begin
            v = int'(v4_val) * 10 + int'(c - CH_ZERO);
            if (v > 255) v4_bad = 1'b1;
            else begin
               v4_val = v[7:0];
               v4_dig = 1'b1;
            end
         end else if (c == CH_DOT) begin
            if (!v4_dig || v4_cnt == 2'd3) v4_bad = 1'b1;
            else begin
               v4_cnt++;
               v4_val = '0;
               v4_dig = 1'b0;
            end
         end else begin
            v4_bad = 1'b1;
         end
      end
      if (!v6_bad) v6_step(c, isdig, ishex);
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // ---- text generators

   function automatic logic [7:0] pick_char();
      string pool;
      pool = "..::0123456789abcdefABCDEFgx- ";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   function automatic string rand_octet();
      int    v;
      string s;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(256, 999);
      else if ($urandom_range(0, 3) == 0) v = $urandom_range(250, 255);
      else v = $urandom_range(0, 255);
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 1) == 1) s = {"0", s};
         else s = {"00", s};
      end
      if ($urandom_range(0, 19) == 0) s = "";
      return s;
   endfunction

   function automatic string mk_v4();
      int    n;
      string s;
      n = 4;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1) ? 3 : 5;
      s = rand_octet();
      for (int i = 1; i < n; i++) s = {s, ".", rand_octet()};
      return s;
   endfunction

   function automatic string rand_hextet();
      string digits;
      string s;
      int    n;
      digits = "0123456789abcdefABCDEF";
      n = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
      s = "";
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0) s = {s, string'(digits[$urandom_range(0, 9)])};
         else s = {s, string'(digits[$urandom_range(0, digits.len() - 1)])};
      end
      return s;
   endfunction

   function automatic string hextets(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = (i == 0) ? rand_hextet() : {s, ":", rand_hextet()};
      return s;
   endfunction

   function automatic string mk_v6();
      bit    tail;
      bit    dc;
      int    need;
      int    n;
      int    k1;
      int    k2;
      string s;
      tail = ($urandom_range(0, 3) == 0);
      dc = $urandom_range(0, 1);
      need = tail ? 6 : 8;
      if (!dc) begin
         n = need;
         if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1) ? need + 1 : need - 1;
         s = hextets(n);
         if (tail) s = {s, ":", mk_v4()};
      end else begin
         n = $urandom_range(0, need - 1);
         if ($urandom_range(0, 9) == 0) n = need;
         k1 = $urandom_range(0, n);
         k2 = n - k1;
         s = {hextets(k1), "::", hextets(k2)};
         if (tail) s = (k2 > 0) ? {s, ":", mk_v4()} : {s, mk_v4()};
      end
      return s;
   endfunction

   // queue one text and its end byte, maybe damaged on the way
   task automatic emit(input string s, input bit mutate);
      text_q_t t;
      int      pos;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      if (mutate) begin
         pos = $urandom_range(0, t.size());
         case ($urandom_range(0, 2))
            0: begin
               if (pos >= t.size()) t.push_back(pick_char());
               else if ($urandom_range(0, 1) == 1) t[pos] = pick_char();
               else t[pos] = 8'($urandom_range(1, 255));
            end
            1: t.insert(pos, pick_char());
            default: begin
               if (pos < t.size()) t.delete(pos);
            end
         endcase
      end
      foreach (t[i]) text_q.push_back(t[i]);
      text_q.push_back(CH_NUL);
      text_count++;
   endtask

   // ---- driver

   int req_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            classify_byte(req_tdata);
            sent_bytes++;
            if (sent_bytes >= calm_mark) calm <= 1'b1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (text_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(1, 100) <= req_idle_pct) begin
               req_gap = $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= text_q.pop_front();
            end
         end
      end
   end

   // ---- monitor

   int rsp_gap;

   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               note_failure($sformatf("result beat with nothing expected: version %0d",
                                      rsp_tdata[1:0]));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[1:0] !== want)
                  note_failure($sformatf("version mismatch: expected %0d, got %0d",
                                         want, rsp_tdata[1:0]));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(1, 100) <= rsp_idle_pct) begin
            rsp_gap = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // cycle count, idle mix and watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles % 64 == 0) begin
         case ($urandom_range(0, 3))
            0: req_idle_pct <= 0;
            1: req_idle_pct <= 5;
            2: req_idle_pct <= 20;
            default: req_idle_pct <= 50;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_idle_pct <= 0;
            1: rsp_idle_pct <= 5;
            2: rsp_idle_pct <= 20;
            default: rsp_idle_pct <= 50;
         endcase
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout: %0d results still expected", verdict_q.size());
         $display("ip_address_text_classifier_core regression: fail");
         $finish;
      end
   end

   initial begin
      int start_len;
      int r;
      clear_state();
      req_idle_pct = 20;
      rsp_idle_pct = 20;

      // directed texts
      emit("", 1'b0);
      emit("0.0.0.0", 1'b0);
      emit("255.255.255.255", 1'b0);
      emit("256.1.1.1", 1'b0);
      emit("1..2.3", 1'b0);
      emit(".1.2.3", 1'b0);
      emit("1.2.3.", 1'b0);
      emit("001.02.0003.4", 1'b0);
      emit("1.2.3.4.5", 1'b0);
      emit("::", 1'b0);
      emit("::1", 1'b0);
      emit(":::", 1'b0);
      emit("1:2:3:4:5:6:7:8", 1'b0);
      emit("1:2:3:4:5:6:7:8:9", 1'b0);
      emit("FfFf:aBcD::09", 1'b0);
      emit("12345::", 1'b0);
      emit("1::2::3", 1'b0);
      emit("::ffff:192.168.0.1", 1'b0);
      emit("1:2:3:4:5:6:1.2.3.4", 1'b0);
      emit("1:2:3:4:5:6:7:1.2.3.4", 1'b0);
      emit("::a1.2.3.4", 1'b0);
      emit("::256.1.1.1", 1'b0);
      emit("::1.2..4", 1'b0);
      emit("::1.2.3.4:5", 1'b0);
      emit("1.2.3.4g", 1'b0);
      text_q.push_back(8'hff);
      text_q.push_back(8'h80);
      text_q.push_back(CH_NUL);
      text_count++;

      // random texts: mostly well-formed with random content, some damaged, some noise
      start_len = text_q.size();
      while (text_q.size() - start_len < RANDOM_BYTES) begin
         r = $urandom_range(0, 9);
         if (r < 4) emit(mk_v4(), $urandom_range(0, 3) == 0);
         else if (r < 8) emit(mk_v6(), $urandom_range(0, 3) == 0);
         else begin
            for (int i = $urandom_range(0, 12); i > 0; i--)
               text_q.push_back($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(1, 255)));
            text_q.push_back(CH_NUL);
            text_count++;
         end
      end
      calm_mark = text_q.size() - CALM_BYTES;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (text_q.size() != 0 || req_tvalid || verdict_q.size() != 0);
      repeat (8) @(posedge clock);
      @(negedge clock);

      if (verdict_q.size() != 0) note_failure("results left over at end of run");
      $display("covered %0d texts in %0d bytes: %0d ipv4, %0d ipv6, %0d invalid",
               text_count, sent_bytes, n_v4, n_v6, n_bad);
      $display("random stalls on both channels, quiet tail, %0d failures", fail_count);
      if (fail_count == 0) begin
         $display("ip_address_text_classifier_core regression: pass");
      end else begin
         $display("ip_address_text_classifier_core regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/iatc_pkg.sv
sv/iatc_v4_chk.sv
sv/iatc_v6_chk.sv
sv/ip_address_text_classifier_core.sv
tb/ip_address_text_classifier_core_tb.sv
